[rtl/lmtc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmtc_pkg
// Types and fixed constants of the LCD mode timing controller.
// ----------------------------------------------------------------------------
package lmtc_pkg;

  localparam int ACC_W  = 10;  // cycle accumulator
  localparam int TICK_W = 6;   // tick cycle count
  localparam int LINE_W = 8;   // line counter

  // Smallest mode limit that the timing parameters may take
  localparam int MIN_LIMIT = 64;

  localparam logic [LINE_W-1:0] FIRST_BLANK_LINE = 8'd144;
  localparam logic [LINE_W-1:0] LINES_PER_FRAME  = 8'd154;

  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_OAM      = 2'd2,
    MODE_TRANSFER = 2'd3
  } mode_t;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_LINE_COMPARE = 3'd0;
  localparam logic [2:0] REG_COIN_IRQ_EN  = 3'd1;
  localparam logic [2:0] REG_OAM_IRQ_EN   = 3'd2;
  localparam logic [2:0] REG_HBLANK_IRQ_EN = 3'd3;
  localparam logic [2:0] REG_DISPLAY_EN   = 3'd4;

  typedef struct packed {
    logic              frame_done;
    logic [LINE_W-1:0] finished_line;
    logic              scanline_done;
    logic              stat_irq;
    logic              vblank_irq;
    logic              coincidence;
    logic [LINE_W-1:0] line_number;
    mode_t             mode;
  } result_t;

endpackage

[rtl/lcd_mode_timing_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_mode_timing_controller
// Scanline mode sequencer driven by cycle-count ticks, with interrupt pulses.
// ----------------------------------------------------------------------------
// Each tick transfer on the in_ stream adds its cycle count to an accumulator.
// When the accumulator exceeds the limit of the current mode (strictly greater)
// it is folded modulo that limit and the mode advances one step:
// OAM search -> transfer -> H-blank -> OAM search, or V-blank after line 143;
// V-blank lines run until line 153, then the line wraps to 0 and OAM search
// starts again. Every tick yields exactly one result on the out_ stream: the
// mode and line after the tick, the line-compare coincidence seen before the
// tick, the V-blank and STAT interrupt pulses, and the scanline/frame strobes
// (gated by display_enable). The update is one add, a set of constant
// compares for the fold and a mode mux, done combinationally between the state
// registers and the result register: one tick per clock is accepted while the
// result register is empty or out_tready is high, and a result appears in the
// cycle after its tick transfer. A result waiting on a stalled out_ side does
// not block a new tick as long as out_tready takes it in the same cycle.
// Configuration writes go through the APB port and are meant for idle periods.
// ----------------------------------------------------------------------------
module lcd_mode_timing_controller
  import lmtc_pkg::*;
#(
  parameter int HBLANK_CYCLES      = 204,
  parameter int VBLANK_LINE_CYCLES = 456,
  parameter int OAM_CYCLES         = 80,
  parameter int TRANSFER_CYCLES    = 172
) (
  input  logic        clk,
  input  logic        rst_n,

  // tick stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [5:0] tick_cycles, [7:6] zero

  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] mode, [9:2] line_number, [10] coincidence, [11] vblank_irq,
  // [12] stat_irq, [13] scanline_done, [21:14] finished_line,
  // [22] frame_done, [23] zero
  output logic [23:0] out_tdata,

  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Limits as accumulator-width constants
  localparam logic [ACC_W-1:0] HblankLim   = ACC_W'(HBLANK_CYCLES);
  localparam logic [ACC_W-1:0] VblankLim   = ACC_W'(VBLANK_LINE_CYCLES);
  localparam logic [ACC_W-1:0] OamLim      = ACC_W'(OAM_CYCLES);
  localparam logic [ACC_W-1:0] TransferLim = ACC_W'(TRANSFER_CYCLES);
  // Largest quotient by the smallest limit that fits in the accumulator
  localparam int MaxQuot = ((1 << ACC_W) - 1) / MIN_LIMIT;

  // Remainder of a by a constant limit: the largest multiple of lim that is
  // not above a is found by parallel compares against constants.
  function automatic logic [ACC_W-1:0] fold(input logic [ACC_W-1:0] a,
                                            input int lim);
    logic [ACC_W-1:0] r;
    logic             found;
    r     = a;
    found = 1'b0;
    for (int k = MaxQuot; k >= 1; k--) begin
      if (!found && (int'(a) >= k * lim)) begin
        r     = a - ACC_W'(k * lim);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [LINE_W-1:0] line_compare_r;
  logic              coin_irq_en_r;
  logic              oam_irq_en_r;
  logic              hblank_irq_en_r;
  logic              display_en_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];   // byte lanes ignored

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_compare_r  <= '0;
      coin_irq_en_r   <= 1'b0;
      oam_irq_en_r    <= 1'b0;
      hblank_irq_en_r <= 1'b0;
      display_en_r    <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LINE_COMPARE:  line_compare_r  <= cfg_pwdata[LINE_W-1:0];
        REG_COIN_IRQ_EN:   coin_irq_en_r   <= cfg_pwdata[0];
        REG_OAM_IRQ_EN:    oam_irq_en_r    <= cfg_pwdata[0];
        REG_HBLANK_IRQ_EN: hblank_irq_en_r <= cfg_pwdata[0];
        REG_DISPLAY_EN:    display_en_r    <= cfg_pwdata[0];
        default: ;  // unmapped, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LINE_COMPARE:  cfg_prdata = {24'd0, line_compare_r};
      REG_COIN_IRQ_EN:   cfg_prdata = {31'd0, coin_irq_en_r};
      REG_OAM_IRQ_EN:    cfg_prdata = {31'd0, oam_irq_en_r};
      REG_HBLANK_IRQ_EN: cfg_prdata = {31'd0, hblank_irq_en_r};
      REG_DISPLAY_EN:    cfg_prdata = {31'd0, display_en_r};
      default:           cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Timing state
  // --------------------------------------------------------------------------
  mode_t             mode_r, mode_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;

  logic              in_xfer;
  logic [ACC_W-1:0]  acc_sum;
  logic              limit_hit;
  logic [LINE_W-1:0] line_inc;
  logic              coin;
  result_t           res;

  assign in_xfer  = in_tvalid && in_tready;
  assign acc_sum  = acc_r + ACC_W'(in_tdata[TICK_W-1:0]);
  assign line_inc = line_r + 8'd1;
  assign coin     = (line_r == line_compare_r);

  // Limit check of the current mode
  always_comb begin
    case (mode_r)
      MODE_HBLANK: limit_hit = acc_sum > HblankLim;
      MODE_VBLANK: limit_hit = acc_sum > VblankLim;
      MODE_OAM:    limit_hit = acc_sum > OamLim;
      default:     limit_hit = acc_sum > TransferLim;
    endcase
  end

  // Next state
  always_comb begin
    mode_nxt = mode_r;
    line_nxt = line_r;
    acc_nxt  = acc_sum;
    if (limit_hit) begin
      case (mode_r)
        MODE_HBLANK: begin
          acc_nxt  = fold(acc_sum, HBLANK_CYCLES);
          line_nxt = line_inc;
          mode_nxt = (line_inc == FIRST_BLANK_LINE) ? MODE_VBLANK : MODE_OAM;
        end
        MODE_VBLANK: begin
          acc_nxt = fold(acc_sum, VBLANK_LINE_CYCLES);
          if (line_inc == LINES_PER_FRAME) begin
            line_nxt = '0;
            mode_nxt = MODE_OAM;
          end else begin
            line_nxt = line_inc;
          end
        end
        MODE_OAM: begin
          acc_nxt  = fold(acc_sum, OAM_CYCLES);
          mode_nxt = MODE_TRANSFER;
        end
        default: begin
          acc_nxt  = fold(acc_sum, TRANSFER_CYCLES);
          mode_nxt = MODE_HBLANK;
        end
      endcase
    end
  end

  // Result fields: pulses raised by the transition of this tick
  always_comb begin
    res               = '0;
    res.mode          = mode_nxt;
    res.line_number   = line_nxt;
    res.coincidence   = coin;
    if (limit_hit) begin
      case (mode_r)
        MODE_HBLANK: begin
          res.scanline_done = display_en_r;
          res.finished_line = display_en_r ? line_r : '0;
          if (line_inc == FIRST_BLANK_LINE) begin
            res.vblank_irq = 1'b1;
          end else begin
            res.stat_irq = oam_irq_en_r;
          end
        end
        MODE_VBLANK: begin
          if (line_inc == LINES_PER_FRAME) begin
            res.frame_done = display_en_r;
            res.stat_irq   = oam_irq_en_r;
          end
        end
        MODE_OAM: ;  // entering transfer raises nothing
        default: begin
          res.stat_irq = (coin_irq_en_r && coin) || hblank_irq_en_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OAM;
      acc_r  <= '0;
      line_r <= '0;
    end else if (in_xfer) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      line_r <= line_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic    out_valid_r;
  result_t out_res_r;

  assign in_tready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_r < LINES_PER_FRAME)
    else $error("line counter beyond last line");

  a_blank_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_VBLANK) |-> (line_r >= FIRST_BLANK_LINE))
    else $error("vblank mode on a visible line");

  a_vblank_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.vblank_irq) |->
      (out_res_r.mode == MODE_VBLANK && out_res_r.line_number == FIRST_BLANK_LINE))
    else $error("vblank pulse without entry to vblank");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.frame_done) |->
      (out_res_r.mode == MODE_OAM && out_res_r.line_number == '0))
    else $error("frame strobe without line wrap");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("accepted tick produced no result");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LCD mode timing controller.
// ----------------------------------------------------------------------------
// Tick transfers go in on the in_ stream and results come back on the out_
// stream. Every accepted tick runs through a cycle-accurate scanline predictor
// kept here, and the expected result is queued. Each result transfer is then
// compared field by field with the oldest entry. A short directed table walks
// the first two lines by hand: the exact-limit cases, the fold remainders, the
// STAT sources, masked register writes and display-off strobes. After it, random
// phases run with fresh register settings, biased toward large ticks so that
// the sequencer gets far into the frame. Both stream sides idle and stall at
// random, with calm phases in between.
// ----------------------------------------------------------------------------
module testbench
  import lmtc_pkg::*;
();

  // Mode limits, passed to the block as well
  localparam int HBLANK_CYCLES      = 204;
  localparam int VBLANK_LINE_CYCLES = 456;
  localparam int OAM_CYCLES         = 80;
  localparam int TRANSFER_CYCLES    = 172;

  localparam int REG_COUNT     = 5;       // registers 5..7 are unused
  localparam int RANDOM_ITEMS  = 1030;
  localparam int PHASE_ITEMS   = 150;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 4;

  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  reg_index;
    logic [31:0] value;      // register data, or tick cycles
    bit          pinned;     // want holds a hand-written result
    result_t     want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;      // [5:0] tick_cycles, [7:6] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [1:0] mode ... [22] frame_done, see DUT
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Travels with each tick so the scoreboard knows which result to queue
  bit          tick_pinned = 1'b0;
  result_t     pinned_result = '0;
  logic        calm = 1'b0;        // no gaps and no stalls while set

  // Scanline predictor state and register copies
  logic [ACC_W-1:0]  timing_acc;
  mode_t             timing_mode;
  logic [LINE_W-1:0] timing_line;
  logic [31:0]       cfg_shadow [REG_COUNT];

  result_t           expected_results [$];
  plan_row_t         plan [$];
  int                failures = 0;
  int                ticks_sent = 0;
  int                cycle_count = 0;
  int                hold_left = 0;

  always #10 clk = ~clk;

  lcd_mode_timing_controller #(
    .HBLANK_CYCLES      (HBLANK_CYCLES),
    .VBLANK_LINE_CYCLES (VBLANK_LINE_CYCLES),
    .OAM_CYCLES         (OAM_CYCLES),
    .TRANSFER_CYCLES    (TRANSFER_CYCLES)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Mostly short pauses, now and then a long one
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // One tick through the scanline sequencer. At most one mode change per
  // tick; the accumulator has to go strictly past the limit to fold.
  function automatic result_t advance_timing(input logic [TICK_W-1:0] cycles);
    result_t     r;
    int unsigned sum;
    logic        display_on;
    r = '0;
    display_on = cfg_shadow[REG_DISPLAY_EN][0];
    sum = timing_acc + cycles;
    r.coincidence = (timing_line == cfg_shadow[REG_LINE_COMPARE][LINE_W-1:0]);
    case (timing_mode)
      MODE_HBLANK: begin
        if (sum > HBLANK_CYCLES) begin
          sum = sum % HBLANK_CYCLES;
          if (display_on) begin
            r.scanline_done = 1'b1;
            r.finished_line = timing_line;
          end
          timing_line = timing_line + 1'b1;
          if (timing_line == FIRST_BLANK_LINE) begin
            timing_mode = MODE_VBLANK;
            r.vblank_irq = 1'b1;
          end else begin
            timing_mode = MODE_OAM;
            r.stat_irq = cfg_shadow[REG_OAM_IRQ_EN][0];
          end
        end
      end
      MODE_VBLANK: begin
        if (sum > VBLANK_LINE_CYCLES) begin
          sum = sum % VBLANK_LINE_CYCLES;
          timing_line = timing_line + 1'b1;
          if (timing_line == LINES_PER_FRAME) begin
            r.frame_done = display_on;
            timing_line = '0;
            timing_mode = MODE_OAM;
            r.stat_irq = cfg_shadow[REG_OAM_IRQ_EN][0];
          end
        end
      end
      MODE_OAM: begin
        if (sum > OAM_CYCLES) begin
          sum = sum % OAM_CYCLES;
          timing_mode = MODE_TRANSFER;
        end
      end
      default: begin
        if (sum > TRANSFER_CYCLES) begin
          sum = sum % TRANSFER_CYCLES;
          timing_mode = MODE_HBLANK;
          // coincidence source and H-blank entry share the one STAT line
          r.stat_irq = (cfg_shadow[REG_COIN_IRQ_EN][0] & r.coincidence) |
                       cfg_shadow[REG_HBLANK_IRQ_EN][0];
        end
      end
    endcase
    timing_acc = sum[ACC_W-1:0];
    r.mode = timing_mode;
    r.line_number = timing_line;
    return r;
  endfunction

  function automatic result_t outcome(mode_t m, logic [LINE_W-1:0] line, logic coin,
                                      logic stat, logic sdone);
    result_t r;
    r = '0;
    r.mode = m;
    r.line_number = line;
    r.coincidence = coin;
    r.stat_irq = stat;
    r.scanline_done = sdone;
    return r;
  endfunction

  function automatic plan_row_t tick_row(logic [TICK_W-1:0] n, bit pinned = 1'b0,
                                         result_t want = '0);
    plan_row_t row;
    row = '{ROW_TICK, '0, 32'(n), pinned, want};
    return row;
  endfunction

  function automatic plan_row_t write_row(logic [2:0] idx, logic [31:0] value);
    plan_row_t row;
    row = '{ROW_WRITE, idx, value, 1'b0, '0};
    return row;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // APB write, then a read-back of the same register where one exists.
  // Called at a rising edge with the port idle.
  task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
    logic [31:0] stored;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx >= REG_COUNT) begin
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
    end else begin
      stored = data & ((idx == REG_LINE_COMPARE) ? 32'h0000_00FF : 32'h0000_0001);
      cfg_shadow[idx] = stored;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
      @(posedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      if (cfg_prdata !== stored) begin
        $error("register %0d read-back mismatch: expected %h, got %h", idx, stored,
               cfg_prdata);
        failures++;
      end
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
    end
    @(posedge clk);
  endtask

  // Offer one tick and hold it until the transfer. in_tvalid stays high
  // across back-to-back ticks.
  task automatic send_tick(input logic [TICK_W-1:0] n, input bit pinned,
                           input result_t want);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_pause();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid     <= 1'b1;
    in_tdata      <= {2'b00, n};
    tick_pinned   <= pinned;
    pinned_result <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering ticks and wait until every queued result has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Scoreboard: both handshakes sampled on the same edge, input side first
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    result_t calc;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        calc = advance_timing(in_tdata[TICK_W-1:0]);
        expected_results.push_back(tick_pinned ? pinned_result : calc);
      end
      if (out_tvalid && out_tready) begin
        seen = result_t'(out_tdata[22:0]);
        if (expected_results.size() == 0) begin
          $error("result transfer with no tick outstanding: %h", out_tdata);
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("mode", want.mode, seen.mode);
          check_field("line_number", want.line_number, seen.line_number);
          check_field("coincidence", want.coincidence, seen.coincidence);
          check_field("vblank_irq", want.vblank_irq, seen.vblank_irq);
          check_field("stat_irq", want.stat_irq, seen.stat_irq);
          check_field("scanline_done", want.scanline_done, seen.scanline_done);
          check_field("finished_line", want.finished_line, seen.finished_line);
          check_field("frame_done", want.frame_done, seen.frame_done);
        end
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      hold_left  <= pick_pause() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [TICK_W-1:0] n;
    logic [7:0]        lc;
    int                style;
    int                r;

    for (int i = 0; i < REG_COUNT; i++) cfg_shadow[i] = '0;
    cfg_shadow[REG_DISPLAY_EN] = 32'd1;
    timing_acc  = '0;
    timing_mode = MODE_OAM;
    timing_line = '0;

    // First two lines by hand. Line 0 matches line_compare 0 out of reset.
    plan.push_back(write_row(REG_COIN_IRQ_EN, 32'd1));
    plan.push_back(write_row(REG_OAM_IRQ_EN, 32'd1));
    plan.push_back(tick_row(6'd0, 1'b1, outcome(MODE_OAM, 8'd0, 1'b1, 1'b0, 1'b0)));
    plan.push_back(tick_row(6'd63, 1'b1, outcome(MODE_OAM, 8'd0, 1'b1, 1'b0, 1'b0)));
    // accumulator lands on the OAM limit exactly: no change yet
    plan.push_back(tick_row(6'd17, 1'b1, outcome(MODE_OAM, 8'd0, 1'b1, 1'b0, 1'b0)));
    plan.push_back(tick_row(6'd1, 1'b1, outcome(MODE_TRANSFER, 8'd0, 1'b1, 1'b0, 1'b0)));
    plan.push_back(tick_row(6'd63));
    plan.push_back(tick_row(6'd63));
    plan.push_back(tick_row(6'd45));
    // transfer end on a coincidence line with its STAT source enabled
    plan.push_back(tick_row(6'd1, 1'b1, outcome(MODE_HBLANK, 8'd0, 1'b1, 1'b1, 1'b0)));
    plan.push_back(tick_row(6'd63));
    plan.push_back(tick_row(6'd63));
    plan.push_back(tick_row(6'd63));
    plan.push_back(tick_row(6'd14));
    // line 0 done, OAM entry raises STAT
    plan.push_back(tick_row(6'd1, 1'b1, outcome(MODE_OAM, 8'd1, 1'b1, 1'b1, 1'b1)));
    plan.push_back(tick_row(6'd63));
    plan.push_back(tick_row(6'd63));   // folds with a remainder of 47
    // display off, H-blank STAT on; upper write bits must be dropped
    plan.push_back(write_row(REG_DISPLAY_EN, 32'hFFFF_FFFE));
    plan.push_back(write_row(REG_HBLANK_IRQ_EN, 32'd1));
    plan.push_back(write_row(REG_COIN_IRQ_EN, 32'd0));
    plan.push_back(write_row(REG_LINE_COMPARE, 32'hA5A5_A5FF));
    plan.push_back(write_row(3'(REG_COUNT), 32'hFFFF_FFFF));
    plan.push_back(tick_row(6'd63));
    plan.push_back(tick_row(6'd63, 1'b1, outcome(MODE_HBLANK, 8'd1, 1'b0, 1'b1, 1'b0)));
    plan.push_back(tick_row(6'd63));
    plan.push_back(tick_row(6'd63));
    plan.push_back(tick_row(6'd63));
    // line ends with display off: no scanline strobe
    plan.push_back(tick_row(6'd63, 1'b1, outcome(MODE_OAM, 8'd2, 1'b0, 1'b1, 1'b0)));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_register(plan[i].reg_index, plan[i].value);
      end else begin
        send_tick(plan[i].value[TICK_W-1:0], plan[i].pinned, plan[i].want);
      end
    end

    // Random phases, each with its own register setting and tick profile
    while (ticks_sent < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0:       lc = 8'd0;
          1:       lc = 8'd255;
          2:       lc = FIRST_BLANK_LINE - 1'b1;
          3:       lc = LINES_PER_FRAME - 1'b1;
          default: lc = timing_line + 8'($urandom_range(0, 12));
        endcase
        write_register(REG_LINE_COMPARE, ($urandom & 32'hFFFF_FF00) | 32'(lc));
      end
      if ($urandom_range(0, 1) == 0)
        write_register(REG_COIN_IRQ_EN, $urandom);
      if ($urandom_range(0, 1) == 0)
        write_register(REG_OAM_IRQ_EN, $urandom);
      if ($urandom_range(0, 1) == 0)
        write_register(REG_HBLANK_IRQ_EN, $urandom);
      if ($urandom_range(0, 1) == 0)
        write_register(REG_DISPLAY_EN, ($urandom & 32'hFFFF_FFFE) |
                                       32'($urandom_range(0, 3) != 0));
      if ($urandom_range(0, 3) == 0)
        write_register(3'($urandom_range(REG_COUNT, 7)), $urandom);

      calm  <= ($urandom_range(0, 4) == 0);
      style = $urandom_range(0, 9);
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (style < 7)       // near-full ticks: moves through the frame fast
          n = (r < 85) ? 6'd63 : 6'($urandom_range(0, 63));
        else if (style < 9)
          n = 6'($urandom_range(0, 63));
        else                 // crawl, lots of sub-limit accumulation
          n = 6'($urandom_range(0, 3));
        send_tick(n, 1'b0, '0);
        ticks_sent++;
      end
    end

    calm <= 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lmtc_pkg.sv
rtl/lcd_mode_timing_controller.sv
bench/testbench.sv
